// ===== design/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define RHPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define RHPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rhps_pkg.sv =====
// shared types, constants and the modulo reduction of the rolling hash search
package rhps_pkg;

    // hash arithmetic
    localparam int HASH_W    = 7;
    localparam int SUM_W     = 15;
    localparam int MODULUS   = 101;
    localparam int HASH_BIAS = MODULUS * 255;
    localparam int RECIP     = 648;

    // defaults
    localparam int PATTERN_MAX_DEF = 8;
    localparam int TEXT_MAX_DEF    = 65536;
    localparam int QUEUE_DEPTH     = 2;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

    // one text item as it travels through the queue
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } item_t;

    // derived pattern state handed from front to back
    typedef struct packed {
        logic [HASH_W-1:0] pattern_hash;
        logic [HASH_W-1:0] high_power;
        logic              busy;
        logic              restart;
    } pat_t;

    // x mod 101 for x below 2^15: reciprocal estimate, then one correction
    function automatic logic [HASH_W-1:0] mod101(input logic [SUM_W-1:0] x);
        logic [24:0] prod;
        logic [15:0] rem;
        prod = 25'(x) * 25'(RECIP);
        rem  = 16'(x) - 16'(prod[24:16]) * 16'(MODULUS);
        if (rem >= 16'(MODULUS))
        begin
            rem = rem - 16'(MODULUS);
        end
        return HASH_W'(rem);
    endfunction

endpackage

// ===== design/rhps_queue.sv =====
// short item queue between the front and the back
module rhps_queue #(
    parameter int DEPTH = rhps_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rhps_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output rhps_pkg::item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rhps_pkg::item_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign valid     = (cnt_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/rhps_front.sv =====
// input acceptance, configuration registers and pattern hash derivation
module rhps_front #(
    parameter int PATTERN_MAX = rhps_pkg::PATTERN_MAX_DEF,
    parameter int M_W         = $clog2(PATTERN_MAX + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rhps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rhps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_byte,
    input  logic                              s_last,
    input  logic                              q_full,
    output logic                              push,
    output rhps_pkg::item_t                   push_item,
    output rhps_pkg::pat_t                    pat,
    output logic [M_W-1:0]                    m_len,
    output logic [rhps_pkg::CFG_DATA_W-1:0]   chars
);

    localparam int SJ_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [rhps_pkg::CFG_DATA_W-1:0] chars_reg, chars_next;
    logic [M_W-1:0]                  m_reg, m_next;
    logic                            busy_reg, busy_next;
    logic                            restart_reg, restart_next;
    logic [SJ_W-1:0]                 step_reg, step_next;
    logic [rhps_pkg::HASH_W-1:0]     ph_reg, ph_next;
    logic [rhps_pkg::HASH_W-1:0]     hp_reg, hp_next;
    logic [7:0]                      pat_byte [PATTERN_MAX];
    logic [rhps_pkg::LEN_W-1:0]      len_raw, len_clamped;
    logic                            last_step;

    // pattern bytes, first character lowest
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            pat_byte[j] = chars_reg[8*j +: 8];
        end
    end

    // length clamped to the usable range
    always_comb
    begin
        len_raw = cfg_data[rhps_pkg::LEN_W-1:0];
        if (len_raw == '0)
        begin
            len_clamped = rhps_pkg::LEN_W'(1);
        end
        else if (len_raw > rhps_pkg::LEN_W'(PATTERN_MAX))
        begin
            len_clamped = rhps_pkg::LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_clamped = len_raw;
        end
    end

    assign last_step = (step_reg == SJ_W'(m_reg - 1'b1));

    // configuration writes, else one pattern byte per cycle into the hashes
    always_comb
    begin
        chars_next   = chars_reg;
        m_next       = m_reg;
        busy_next    = busy_reg;
        restart_next = 1'b0;
        step_next    = step_reg;
        ph_next      = ph_reg;
        hp_next      = hp_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rhps_pkg::CFG_PATTERN_CHARS:
                begin
                    chars_next = cfg_data;
                end
                rhps_pkg::CFG_PATTERN_LENGTH:
                begin
                    m_next       = M_W'(len_clamped);
                    restart_next = 1'b1;
                end
                default:
                begin
                    chars_next = chars_reg;
                end
            endcase
            busy_next = 1'b1;
            step_next = '0;
            ph_next   = '0;
            hp_next   = rhps_pkg::HASH_W'(1);
        end
        else if (busy_reg)
        begin
            ph_next = rhps_pkg::mod101({ph_reg, pat_byte[step_reg]});
            if (!last_step)
            begin
                hp_next   = rhps_pkg::mod101({hp_reg, 8'h00});
                step_next = step_reg + 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg   <= '0;
            m_reg       <= M_W'(1);
            busy_reg    <= 1'b0;
            restart_reg <= 1'b0;
            step_reg    <= '0;
            ph_reg      <= '0;
            hp_reg      <= rhps_pkg::HASH_W'(1);
        end
        else
        begin
            chars_reg   <= chars_next;
            m_reg       <= m_next;
            busy_reg    <= busy_next;
            restart_reg <= restart_next;
            step_reg    <= step_next;
            ph_reg      <= ph_next;
            hp_reg      <= hp_next;
        end
    end

    // items wait while the pattern hash is being rebuilt or the queue is full
    assign s_ready             = !busy_reg && !q_full;
    assign push                = s_valid && s_ready;
    assign push_item.text_byte = s_byte;
    assign push_item.last_byte = s_last;

    assign pat.pattern_hash = ph_reg;
    assign pat.high_power   = hp_reg;
    assign pat.busy         = busy_reg;
    assign pat.restart      = restart_reg;
    assign m_len            = m_reg;
    assign chars            = chars_reg;

endmodule

// ===== design/rhps_back.sv =====
// rolling hash update, window compare and result register
module rhps_back #(
    parameter int PATTERN_MAX = rhps_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = rhps_pkg::TEXT_MAX_DEF,
    parameter int M_W         = $clog2(PATTERN_MAX + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  rhps_pkg::item_t                 q_item,
    output logic                            pop,
    input  rhps_pkg::pat_t                  pat,
    input  logic [M_W-1:0]                  m_len,
    input  logic [rhps_pkg::CFG_DATA_W-1:0] chars,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [15:0]                     out_position,
    output logic                            out_found
);

    localparam int CNT_W     = $clog2(TEXT_MAX + 1);
    localparam int WIN_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int POS_CAP   = (TEXT_MAX - 1 > 65535) ? 65535 : TEXT_MAX - 1;
    localparam int POS_W     = (CNT_W > 16) ? CNT_W : 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUB,
        S_ROLL,
        S_CHECK
    } state_t;

    state_t                       state_reg, state_next;
    logic [rhps_pkg::HASH_W-1:0]  hash_reg, hash_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         found_any_reg, found_any_next;
    logic                         out_valid_reg, out_valid_next;
    logic [15:0]                  out_pos_reg, out_pos_next;
    logic                         out_found_reg, out_found_next;

    logic [7:0]                   byte_reg;
    logic                         last_reg;
    logic [rhps_pkg::SUM_W-1:0]   prod_reg;
    logic [rhps_pkg::HASH_W-1:0]  t_reg;
    logic [7:0]                   window_reg [PATTERN_MAX];
    logic [7:0]                   pat_byte [PATTERN_MAX];

    logic                         count_full;
    logic [rhps_pkg::SUM_W-1:0]   diff;
    logic                         same;
    logic                         match;
    logic                         emit;
    logic                         can_load;
    logic [CNT_W-1:0]             pos_full, pos_cap;
    logic [POS_W-1:0]             pos_ext;
    logic [WIN_IDX_W-1:0]         old_idx;

    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            pat_byte[j] = chars[8*j +: 8];
        end
    end

    assign old_idx    = WIN_IDX_W'(m_len - 1'b1);
    assign count_full = (count_reg >= CNT_W'(m_len));
    assign pop        = (state_reg == S_IDLE) && q_valid && !pat.restart;

    // oldest byte term leaves the hash
    assign diff = rhps_pkg::SUM_W'(hash_reg) + rhps_pkg::SUM_W'(rhps_pkg::HASH_BIAS) - prod_reg;

    // window against pattern, oldest byte against first character
    always_comb
    begin
        same = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if ((M_W'(j) < m_len) &&
                (window_reg[WIN_IDX_W'(m_len - 1'b1 - M_W'(j))] != pat_byte[j]))
            begin
                same = 1'b0;
            end
        end
    end

    assign match    = count_full && (hash_reg == pat.pattern_hash) && same;
    assign emit     = match || (last_reg && !found_any_reg);
    assign can_load = !out_valid_reg || out_ready;

    // start position, saturated
    always_comb
    begin
        pos_full = count_reg - CNT_W'(m_len);
        pos_cap  = (pos_full > CNT_W'(POS_CAP)) ? CNT_W'(POS_CAP) : pos_full;
        pos_ext  = POS_W'(pos_cap);
    end

    // sequencer over the hash steps of one item
    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        count_next     = count_reg;
        found_any_next = found_any_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_pos_next   = out_pos_reg;
        out_found_next = out_found_reg;
        if (pat.restart)
        begin
            state_next     = S_IDLE;
            hash_next      = '0;
            count_next     = '0;
            found_any_next = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_next = S_SUB;
                    end
                end
                S_SUB:
                begin
                    state_next = S_ROLL;
                end
                S_ROLL:
                begin
                    hash_next  = rhps_pkg::mod101({t_reg, byte_reg});
                    count_next = (count_reg == CNT_W'(TEXT_MAX)) ? count_reg
                                                                 : count_reg + 1'b1;
                    state_next = S_CHECK;
                end
                S_CHECK:
                begin
                    if (!emit || can_load)
                    begin
                        if (emit)
                        begin
                            out_valid_next = 1'b1;
                            out_pos_next   = match ? pos_ext[15:0] : 16'h0000;
                            out_found_next = match;
                        end
                        if (match)
                        begin
                            found_any_next = 1'b1;
                        end
                        if (last_reg)
                        begin
                            hash_next      = '0;
                            count_next     = '0;
                            found_any_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hash_reg      <= '0;
            count_reg     <= '0;
            found_any_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pos_reg   <= '0;
            out_found_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            count_reg     <= count_next;
            found_any_reg <= found_any_next;
            out_valid_reg <= out_valid_next;
            out_pos_reg   <= out_pos_next;
            out_found_reg <= out_found_next;
        end
    end

    // item payload, partial products and the byte window
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg <= q_item.text_byte;
            last_reg <= q_item.last_byte;
            prod_reg <= rhps_pkg::SUM_W'(pat.high_power) *
                        rhps_pkg::SUM_W'(window_reg[old_idx]);
        end
        if (state_reg == S_SUB)
        begin
            t_reg <= count_full ? rhps_pkg::mod101(diff) : hash_reg;
        end
        if (state_reg == S_ROLL && !pat.restart)
        begin
            for (int j = PATTERN_MAX - 1; j > 0; j--)
            begin
                window_reg[j] <= window_reg[j-1];
            end
            window_reg[0] <= byte_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_position = out_pos_reg;
    assign out_found    = out_found_reg;

endmodule

// ===== design/rolling_hash_pattern_search.sv =====
// A result is registered after its text item passes the queue and the back-end states
// S_SUB, S_ROLL and S_CHECK. The back end takes a new item only once done with the last,
// through its hash sequence (oldest-byte product, subtract and reduce, shift in and reduce,
// compare). A pattern or length write holds off input while the pattern hash is derived.
// Reset clears control state; the pattern reads as length 1, all zero bytes.
// rolling hash pattern search top level
`include "assert_macros.svh"

module rolling_hash_pattern_search #(
    parameter int PATTERN_MAX = rhps_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = rhps_pkg::TEXT_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rhps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rhps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // text_byte
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,   // position
    output logic                            m_axis_tuser    // found
);

    localparam int M_W = $clog2(PATTERN_MAX + 1);

    logic                            push;
    rhps_pkg::item_t                 push_item;
    logic                            q_full;
    logic                            q_valid;
    rhps_pkg::item_t                 q_item;
    logic                            pop;
    rhps_pkg::pat_t                  pat;
    logic [M_W-1:0]                  m_len;
    logic [rhps_pkg::CFG_DATA_W-1:0] chars;

    // front: configuration, pattern hash and input acceptance
    rhps_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .M_W         (M_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_byte    (s_axis_tdata),
        .s_last    (s_axis_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item),
        .pat       (pat),
        .m_len     (m_len),
        .chars     (chars)
    );

    // item queue
    rhps_queue #(
        .DEPTH (rhps_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head_item (q_item)
    );

    // back: rolling hash and match
    rhps_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX),
        .M_W         (M_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop),
        .pat          (pat),
        .m_len        (m_len),
        .chars        (chars),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_position (m_axis_tdata),
        .out_found    (m_axis_tuser)
    );

    // checks
    `RHPS_ASSERT_IMP(a_no_accept_busy, s_axis_tvalid && s_axis_tready, !pat.busy, "item taken during pattern derivation")
    `RHPS_ASSERT_IMP(a_no_push_full, push, !q_full, "queue push while full")
    `RHPS_ASSERT_NXT(a_len_rederive, cfg_we && (cfg_index == rhps_pkg::CFG_PATTERN_LENGTH), pat.busy && pat.restart, "length write did not restart")
    `RHPS_ASSERT_IMP(a_notfound_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 16'h0000, "not-found result with nonzero position")

endmodule
